### src/mfwr3d_pkg.sv
// ----------------------------------------------------------------------------
// mfwr3d_pkg
// Shared types and constants for the masked 3-D full-weighting restriction.
// ----------------------------------------------------------------------------
package mfwr3d_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // register widths and reset values
    localparam int SIZE_X_W = 8;
    localparam int SIZE_Y_W = 8;
    localparam int SIZE_Z_W = 11;
    localparam logic [SIZE_X_W-1:0] SIZE_X_RST = 8'd128;
    localparam logic [SIZE_Y_W-1:0] SIZE_Y_RST = 8'd128;
    localparam logic [SIZE_Z_W-1:0] SIZE_Z_RST = 11'd1024;

    // coarse index widths
    localparam int CX_W = 6;
    localparam int CY_W = 6;
    localparam int CZ_W = 9;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    // per-item control that follows a voxel down the pipeline
    typedef struct packed {
        logic            hit;
        logic            x_odd;
        logic            y_odd;
        logic            z_odd;
        logic            interior;
        logic            last;
        logic [CX_W-1:0] cx;
        logic [CY_W-1:0] cy;
        logic [CZ_W-1:0] cz;
    } item_info_t;

endpackage

### src/mfwr3d_ram.sv
// ----------------------------------------------------------------------------
// mfwr3d_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfwr3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/masked_full_weighting_restrict_3d.sv
// ----------------------------------------------------------------------------
// masked_full_weighting_restrict_3d
// Masked 27-point full-weighting restriction of a raster-ordered voxel stream.
// ----------------------------------------------------------------------------
// Throughput: one fine voxel per cycle while the input is not stalled, set by the
//   single read-modify-write port of the plane memory and of the row memory.
// Flow: a coarse voxel passes the pipeline stages and then an 8-entry queue on
//   its way to the output once the fine voxel completing its neighborhood is accepted;
//   input stalls while 8 results are queued or in flight.
// Reset: rst_n clears position, pipeline valids and queue; size registers go
//   to their maximum. History memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module masked_full_weighting_restrict_3d #(
    parameter int MAX_X       = 128,
    parameter int MAX_Y       = 128,
    parameter int MAX_Z       = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,

    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // sample_value, sample_mask
    input  logic [((SAMPLE_BITS+1+7)/8)*8-1:0]      s_tdata,

    // output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // coarse_value, coarse_mask, coarse_x, coarse_y, coarse_z
    output logic [((SAMPLE_BITS+22+7)/8)*8-1:0]     m_tdata,
    output logic                                    m_tlast,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int EW     = SB + 1;
    localparam int XW     = $clog2(MAX_X);
    localparam int YW     = $clog2(MAX_Y);
    localparam int ZW     = $clog2(MAX_Z);
    localparam int PLANE  = MAX_X * MAX_Y;
    localparam int AW     = $clog2(PLANE);
    localparam int BW     = $clog2(MAX_X);
    localparam int SW     = SB + 8;
    localparam int OUT_W  = SB + 22;
    localparam int TD_W   = ((SB + 22 + 7) / 8) * 8;
    localparam int Q_W    = OUT_W + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [mfwr3d_pkg::SIZE_X_W-1:0] size_x_reg;
    logic [mfwr3d_pkg::SIZE_Y_W-1:0] size_y_reg;
    logic [mfwr3d_pkg::SIZE_Z_W-1:0] size_z_reg;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= mfwr3d_pkg::SIZE_X_RST;
            size_y_reg <= mfwr3d_pkg::SIZE_Y_RST;
            size_z_reg <= mfwr3d_pkg::SIZE_Z_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                mfwr3d_pkg::REG_SIZE_X: size_x_reg <= pwdata[mfwr3d_pkg::SIZE_X_W-1:0];
                mfwr3d_pkg::REG_SIZE_Y: size_y_reg <= pwdata[mfwr3d_pkg::SIZE_Y_W-1:0];
                mfwr3d_pkg::REG_SIZE_Z: size_z_reg <= pwdata[mfwr3d_pkg::SIZE_Z_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            mfwr3d_pkg::REG_SIZE_X: prdata = 32'(size_x_reg);
            mfwr3d_pkg::REG_SIZE_Y: prdata = 32'(size_y_reg);
            mfwr3d_pkg::REG_SIZE_Z: prdata = 32'(size_z_reg);
            default:                prdata = 32'd0;
        endcase
    end

    // clamp sizes to [1, MAX]
    logic [31:0] sx32, sy32, sz32;
    logic [XW:0] sx;
    logic [YW:0] sy;
    logic [ZW:0] sz;

    always_comb
    begin
        sx32 = 32'(size_x_reg);
        sy32 = 32'(size_y_reg);
        sz32 = 32'(size_z_reg);
        if (sx32 == 32'd0) sx32 = 32'd1;
        else if (sx32 > 32'(MAX_X)) sx32 = 32'(MAX_X);
        if (sy32 == 32'd0) sy32 = 32'd1;
        else if (sy32 > 32'(MAX_Y)) sy32 = 32'(MAX_Y);
        if (sz32 == 32'd0) sz32 = 32'd1;
        else if (sz32 > 32'(MAX_Z)) sz32 = 32'(MAX_Z);
        sx = sx32[XW:0];
        sy = sy32[YW:0];
        sz = sz32[ZW:0];
    end

    // ------------------------------------------------------------------
    // raster position and item decode
    // ------------------------------------------------------------------
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;
    logic          x_end, y_end, z_end;
    logic          accept;
    mfwr3d_pkg::item_info_t in_info;

    logic [mfwr3d_pkg::FIFO_CNT_W-1:0] q_cnt_reg;
    logic                              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    mfwr3d_pkg::item_info_t            s1_info_reg, s2_info_reg, s3_info_reg;
    logic [mfwr3d_pkg::FIFO_CNT_W:0]   pending;

    // credits: queue entries plus results still in the pipeline
    assign pending  = (mfwr3d_pkg::FIFO_CNT_W+1)'(q_cnt_reg)
                    + (mfwr3d_pkg::FIFO_CNT_W+1)'(s1_valid_reg & s1_info_reg.hit)
                    + (mfwr3d_pkg::FIFO_CNT_W+1)'(s2_valid_reg & s2_info_reg.hit)
                    + (mfwr3d_pkg::FIFO_CNT_W+1)'(s3_valid_reg & s3_info_reg.hit);
    assign s_tready = pending < (mfwr3d_pkg::FIFO_CNT_W+1)'(mfwr3d_pkg::FIFO_DEPTH);
    assign accept   = s_tvalid & s_tready;

    assign x_end = ((XW+1)'(x_reg) + (XW+1)'(1)) == sx;
    assign y_end = ((YW+1)'(y_reg) + (YW+1)'(1)) == sy;
    assign z_end = ((ZW+1)'(z_reg) + (ZW+1)'(1)) == sz;

    always_comb
    begin
        x_next = x_reg + XW'(1);
        y_next = y_reg;
        z_next = z_reg;
        if (x_end)
        begin
            x_next = '0;
            y_next = y_reg + YW'(1);
            if (y_end)
            begin
                y_next = '0;
                z_next = z_end ? '0 : z_reg + ZW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (accept)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // which coarse voxel this fine voxel completes
    always_comb
    begin
        in_info.x_odd    = x_reg[0];
        in_info.y_odd    = y_reg[0];
        in_info.z_odd    = z_reg[0];
        in_info.hit      = (x_reg[0] | x_end) & (y_reg[0] | y_end) & (z_reg[0] | z_end);
        in_info.interior = x_reg[0] & (x_reg != XW'(1))
                         & y_reg[0] & (y_reg != YW'(1))
                         & z_reg[0] & (z_reg != ZW'(1));
        in_info.last     = x_end & y_end & z_end;
        in_info.cx       = mfwr3d_pkg::CX_W'(x_reg >> 1);
        in_info.cy       = mfwr3d_pkg::CY_W'(y_reg >> 1);
        in_info.cz       = mfwr3d_pkg::CZ_W'(z_reg >> 1);
    end

    // ------------------------------------------------------------------
    // history memories: plane store holds z-1, z-2 per (x, y);
    // row store holds the z columns of rows y-1, y-2 per x
    // ------------------------------------------------------------------
    logic [AW-1:0]   a_rd_addr;
    logic [BW-1:0]   b_rd_addr;
    logic [AW-1:0]   s1_a_addr_reg;
    logic [BW-1:0]   s1_b_addr_reg;
    logic [2*EW-1:0] a_rd_data, a_wr_data, a_word, a_fwd_reg;
    logic [6*EW-1:0] b_rd_data, b_wr_data, b_word, b_fwd_reg;
    logic            a_fwd_hit_reg, b_fwd_hit_reg;
    logic [EW-1:0]   s1_elem_reg;
    logic [3*EW-1:0] col_t;

    assign a_rd_addr = AW'(y_reg) * AW'(MAX_X) + AW'(x_reg);
    assign b_rd_addr = BW'(x_reg);

    mfwr3d_ram #(
        .WIDTH (2*EW),
        .DEPTH (PLANE)
    ) u_plane_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_a_addr_reg),
        .wr_data (a_wr_data),
        .rd_en   (accept),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mfwr3d_ram #(
        .WIDTH (6*EW),
        .DEPTH (MAX_X)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_b_addr_reg),
        .wr_data (b_wr_data),
        .rd_en   (accept),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // stage 1 registers with forwarding of the write in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            a_fwd_hit_reg <= 1'b0;
            b_fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            a_fwd_hit_reg <= accept & s1_valid_reg & (a_rd_addr == s1_a_addr_reg);
            b_fwd_hit_reg <= accept & s1_valid_reg & (b_rd_addr == s1_b_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a_addr_reg <= a_rd_addr;
            s1_b_addr_reg <= b_rd_addr;
            s1_elem_reg   <= {s_tdata[SB], s_tdata[SB-1:0]};
            s1_info_reg   <= in_info;
        end
        a_fwd_reg <= a_wr_data;
        b_fwd_reg <= b_wr_data;
    end

    // z column at (x, y): {current, z-1, z-2}; rows shift in the row store
    assign a_word    = a_fwd_hit_reg ? a_fwd_reg : a_rd_data;
    assign b_word    = b_fwd_hit_reg ? b_fwd_reg : b_rd_data;
    assign col_t     = {s1_elem_reg, a_word};
    assign a_wr_data = {s1_elem_reg, a_word[2*EW-1:EW]};
    assign b_wr_data = {col_t, b_word[6*EW-1:3*EW]};

    // ------------------------------------------------------------------
    // stage 2: 3x3x3 window, columns x-2, x-1, x
    // ------------------------------------------------------------------
    logic [9*EW-1:0] win_reg [3];
    logic [9*EW-1:0] xsec;

    // cross-section rows y-2, y-1, y, each planes z-2, z-1, z
    assign xsec = {col_t, b_word};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_reg[0]  <= win_reg[1];
            win_reg[1]  <= win_reg[2];
            win_reg[2]  <= xsec;
            s2_info_reg <= s1_info_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // weighted column sums, centre pick, mask check
    logic signed [SW-1:0] colsum [3];
    logic [EW-1:0]        centre;
    logic                 all_mask;
    logic [1:0]           csel, rsel, psel_c;

    always_comb
    begin
        logic [EW-1:0] e;
        logic signed [SW-1:0] acc;
        all_mask = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            acc = '0;
            for (int k = 0; k < 9; k++)
            begin
                e = win_reg[c][k*EW +: EW];
                all_mask = all_mask & e[SB];
                acc = acc + ((SW'(signed'(e[SB-1:0])))
                        <<< (((k / 3) == 1 ? 1 : 0) + ((k % 3) == 1 ? 1 : 0)));
            end
            colsum[c] = acc;
        end
        csel   = s2_info_reg.x_odd ? 2'd1 : 2'd2;
        rsel   = s2_info_reg.y_odd ? 2'd1 : 2'd2;
        psel_c = s2_info_reg.z_odd ? 2'd1 : 2'd2;
        centre = win_reg[csel][(rsel*3 + psel_c)*EW +: EW];
    end

    // ------------------------------------------------------------------
    // stage 3: total, rounding, result select
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s3_col_reg [3];
    logic [EW-1:0]        s3_centre_reg;
    logic                 s3_full_reg;
    logic signed [SW-1:0] total;
    logic [SB-1:0]        res_value;
    logic [OUT_W:0]       q_wr_word;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_col_reg[0] <= colsum[0];
            s3_col_reg[1] <= colsum[1];
            s3_col_reg[2] <= colsum[2];
            s3_centre_reg <= centre;
            s3_full_reg   <= all_mask;
            s3_info_reg   <= s2_info_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        total = s3_col_reg[0] + (s3_col_reg[1] <<< 1) + s3_col_reg[2] + SW'(32);
        if (!s3_centre_reg[SB])
            res_value = '0;
        else if (s3_info_reg.interior && s3_full_reg)
            res_value = total[SB+5:6];
        else
            res_value = s3_centre_reg[SB-1:0];
        q_wr_word = {s3_info_reg.last, s3_info_reg.cz, s3_info_reg.cy, s3_info_reg.cx,
                     s3_centre_reg[SB], res_value};
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    logic [Q_W-1:0]                    q_mem_reg [mfwr3d_pkg::FIFO_DEPTH];
    logic [mfwr3d_pkg::FIFO_PTR_W-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic                              q_push, q_pop;
    logic [Q_W-1:0]                    q_head;

    assign q_push = s3_valid_reg & s3_info_reg.hit;
    assign q_pop  = m_tvalid & m_tready;

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_ptr_reg] <= q_wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            if (q_push) q_wr_ptr_reg <= q_wr_ptr_reg + 1'b1;
            if (q_pop)  q_rd_ptr_reg <= q_rd_ptr_reg + 1'b1;
            q_cnt_reg <= q_cnt_reg + mfwr3d_pkg::FIFO_CNT_W'(q_push)
                                   - mfwr3d_pkg::FIFO_CNT_W'(q_pop);
        end
    end

    assign q_head   = q_mem_reg[q_rd_ptr_reg];
    assign m_tvalid = q_cnt_reg != '0;
    assign m_tdata  = TD_W'(q_head[OUT_W-1:0]);
    assign m_tlast  = q_head[OUT_W];

endmodule

### tb/tb_masked_full_weighting_restrict_3d.sv
// ----------------------------------------------------------------------------
// tb_masked_full_weighting_restrict_3d
// Self-checking testbench for the masked 27-point restriction block: drives
// fine voxel grids of many shapes through the input stream, predicts every
// coarse voxel with an in-bench copy of the plane history and compares each
// output transaction with the expected one, showing each field on a mismatch.
// ----------------------------------------------------------------------------
module tb_masked_full_weighting_restrict_3d;

    localparam int PLANE = 128 * 128;

    typedef struct packed {
        logic [23:0]                 value;
        logic                        mask;
        logic [mfwr3d_pkg::CX_W-1:0] cx;
        logic [mfwr3d_pkg::CY_W-1:0] cy;
        logic [mfwr3d_pkg::CZ_W-1:0] cz;
        logic                        last;
    } coarse_voxel_t;

    // one directed row: grid shape, fine voxel, and a typed result where obvious
    typedef struct {
        int            sx, sy, sz;
        logic [23:0]   value;
        logic          mask;
        bit            typed;
        coarse_voxel_t res;
    } voxel_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // sample_value[23:0], sample_mask[24]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // coarse_value[23:0], coarse_mask, coarse_x, coarse_y, coarse_z
    logic        m_tlast;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    masked_full_weighting_restrict_3d i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [23:0]     hist_val [3*PLANE];
    bit              hist_msk [3*PLANE];
    logic [10:0]     reg_sx, reg_sy, reg_sz;
    int              pos_x, pos_y, pos_z;
    coarse_voxel_t   pending_voxels [$];

    int  n_items, n_results, n_weighted, n_grids, errors;
    bit  idle_on;
    bit  hold_req;
    int  hold_cnt;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int clamp_extent(int v, int top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic int plane_cell(int x, int y, int z);
        return (z % 3) * PLANE + y * 128 + x;
    endfunction

    // even coordinate completed by fine coordinate t on an axis of extent n
    function automatic bit completes(int t, int n, output int c);
        c = 0;
        if (t % 2 == 1) begin c = t - 1; return 1; end
        if (t + 1 == n) begin c = t; return 1; end
        return 0;
    endfunction

    // restriction predictor: absorbs one fine voxel, may yield a coarse voxel
    function automatic bit restrict_voxel(logic [23:0] v, logic m,
                                          output coarse_voxel_t r);
        int    sx, sy, sz, x, y, z, cx, cy, cz, c, off;
        bit    hit, all_in;
        longint sum;
        sx = clamp_extent(reg_sx, 128);
        sy = clamp_extent(reg_sy, 128);
        sz = clamp_extent(reg_sz, 1024);
        x = pos_x; y = pos_y; z = pos_z;
        r = '0;
        if (x >= sx || y >= sy || z >= sz) begin x = 0; y = 0; z = 0; end
        hist_val[plane_cell(x, y, z)] = v;
        hist_msk[plane_cell(x, y, z)] = m;
        hit = completes(x, sx, cx) && completes(y, sy, cy) && completes(z, sz, cz);
        // raster advance
        pos_x = x + 1; pos_y = y; pos_z = z;
        if (pos_x >= sx) begin
            pos_x = 0; pos_y = y + 1;
            if (pos_y >= sy) begin
                pos_y = 0; pos_z = z + 1;
                if (pos_z >= sz) pos_z = 0;
            end
        end
        if (!hit) return 0;
        if (hist_msk[plane_cell(cx, cy, cz)]) begin
            r.mask  = 1'b1;
            r.value = hist_val[plane_cell(cx, cy, cz)];
            if (cx >= 1 && cx + 2 <= sx && cy >= 1 && cy + 2 <= sy &&
                cz >= 1 && cz + 2 <= sz) begin
                sum = 0;
                all_in = 1;
                for (int dz = -1; dz <= 1; dz++)
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++) begin
                            c = plane_cell(cx + dx, cy + dy, cz + dz);
                            off = (dx != 0) + (dy != 0) + (dz != 0);
                            all_in &= hist_msk[c];
                            sum += longint'($signed(hist_val[c])) * (8 >> off);
                        end
                if (all_in) begin
                    sum = (sum + 32) >>> 6;
                    r.value = sum[23:0];
                    n_weighted++;
                end
            end
        end
        r.cx = mfwr3d_pkg::CX_W'(cx >> 1);
        r.cy = mfwr3d_pkg::CY_W'(cy >> 1);
        r.cz = mfwr3d_pkg::CZ_W'(cz >> 1);
        r.last = (x + 1 == sx && y + 1 == sy && z + 1 == sz);
        return 1;
    endfunction

    // register write, setup then access cycle
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            mfwr3d_pkg::REG_SIZE_X: reg_sx = 11'(data[7:0]);
            mfwr3d_pkg::REG_SIZE_Y: reg_sy = 11'(data[7:0]);
            default:                reg_sz = data[10:0];
        endcase
        pos_x = 0; pos_y = 0; pos_z = 0;
    endtask

    // drain outstanding results, let the pipeline empty, then reshape the grid
    task automatic set_grid(int sx, int sy, int sz);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_voxels.size() == 0);
        repeat (12) @(negedge clk);
        write_reg(mfwr3d_pkg::REG_SIZE_X, sx);
        write_reg(mfwr3d_pkg::REG_SIZE_Y, sy);
        write_reg(mfwr3d_pkg::REG_SIZE_Z, sz);
        n_grids++;
    endtask

    // one input transaction; typed result overrides the predicted one
    task automatic send_voxel(logic [23:0] v, logic m, bit typed = 0,
                              coarse_voxel_t typed_res = '0);
        coarse_voxel_t r;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, m, v};
        do @(posedge clk); while (!s_tready);
        n_items++;
        if (restrict_voxel(v, m, r))
            pending_voxels.push_back(typed ? typed_res : r);
    endtask

    // receiver readiness, with a single long hold-off
    initial begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 14);
            end
        end
    end

    // output checking
    always @(posedge clk) begin
        coarse_voxel_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[23:0], m_tdata[24], m_tdata[30:25], m_tdata[36:31],
                   m_tdata[45:37], m_tlast};
            n_results++;
            if (pending_voxels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected coarse voxel value=%h mask=%b ",
                             "xyz=%0d,%0d,%0d last=%b",
                             got.value, got.mask, got.cx, got.cy, got.cz, got.last);
            end else begin
                want = pending_voxels.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp value=%h mask=%b xyz=%0d,%0d,%0d last=%b",
                                 want.value, want.mask, want.cx, want.cy, want.cz,
                                 want.last,
                                 " / got value=%h mask=%b xyz=%0d,%0d,%0d last=%b",
                                 got.value, got.mask, got.cx, got.cy, got.cz, got.last);
                end
            end
        end
    end

    // run limit
    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin
        voxel_row_t    rows [$];
        coarse_voxel_t t;
        int            sx, sy, sz, total, cnt, grids, mask_pct, r;
        logic [23:0]   v;
        bit            paused;
        bit            held;
        bit            fill_run;

        s_tvalid = 1'b0; s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        hold_req = 0; idle_on = 1; paused = 0; held = 0;
        n_items = 0; n_results = 0; n_weighted = 0; n_grids = 0; errors = 0;
        reg_sx = 11'(mfwr3d_pkg::SIZE_X_RST);
        reg_sy = 11'(mfwr3d_pkg::SIZE_Y_RST);
        reg_sz = mfwr3d_pkg::SIZE_Z_RST;
        pos_x = 0; pos_y = 0; pos_z = 0;
        foreach (hist_val[i]) begin hist_val[i] = '0; hist_msk[i] = 0; end
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single voxel grid: every voxel is its own last coarse voxel, centre copy
        t = '{value: 24'h7FFFFF, mask: 1, cx: 0, cy: 0, cz: 0, last: 1};
        rows.push_back('{1, 1, 1, 24'h7FFFFF, 1, 1, t});
        t.value = 24'h800000;
        rows.push_back('{1, 1, 1, 24'h800000, 1, 1, t});
        t.value = 24'hFFFFFF;
        rows.push_back('{1, 1, 1, 24'hFFFFFF, 1, 1, t});
        t.value = 24'h000000;
        rows.push_back('{1, 1, 1, 24'h000000, 1, 1, t});
        // masked off gives zero value and zero mask
        t.value = 24'h000000; t.mask = 0;
        rows.push_back('{1, 1, 1, 24'h7FFFFF, 0, 1, t});
        rows.push_back('{1, 1, 1, 24'hAAAAAA, 0, 1, t});
        t.value = 24'h555555; t.mask = 1;
        rows.push_back('{1, 1, 1, 24'h555555, 1, 1, t});
        // zero extents clamp to one
        t.value = 24'h123456;
        rows.push_back('{0, 0, 0, 24'h123456, 1, 1, t});
        // flat x axis of two: odd voxel completes, even voxel yields nothing
        rows.push_back('{2, 1, 1, 24'h0F0F0F, 1, 0, t});
        rows.push_back('{2, 1, 1, 24'hF0F0F0, 0, 0, t});
        rows.push_back('{2, 1, 1, 24'h800000, 0, 0, t});
        rows.push_back('{2, 1, 1, 24'h7FFFFF, 1, 0, t});
        // 1x3x1 column and 1x1x2 pillar
        for (int i = 0; i < 3; i++)
            rows.push_back('{1, 3, 1, 24'(24'h3C3C3C + i), 1, 0, t});
        rows.push_back('{1, 1, 2, 24'hC3C3C3, 1, 0, t});
        rows.push_back('{1, 1, 2, 24'h000001, 1, 0, t});

        sx = -1; sy = -1; sz = -1;
        foreach (rows[i]) begin
            if (rows[i].sx != sx || rows[i].sy != sy || rows[i].sz != sz) begin
                sx = rows[i].sx; sy = rows[i].sy; sz = rows[i].sz;
                set_grid(sx, sy, sz);
            end
            send_voxel(rows[i].value, rows[i].mask, rows[i].typed, rows[i].res);
        end

        // extreme extents: x above range, y at its top, z partially streamed
        set_grid(255, 1, 2);
        repeat (256) send_voxel(24'($urandom), 1'b1);
        set_grid(1, 128, 2);
        repeat (256) send_voxel(24'($urandom), $urandom_range(99) < 90);
        set_grid(1, 1, 2047);
        repeat (70) send_voxel(24'($urandom), 1'b1);

        // random grids, mostly small and dense so the interior weighting fires;
        // the first one is a full 8x8x7 grid streamed against a long hold-off
        while (n_items < 1300) begin
            sx = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
            sy = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
            sz = $urandom_range(1, 7);
            fill_run = !held;
            if (fill_run) begin sx = 8; sy = 8; sz = 7; end
            set_grid(sx, sy, sz);
            total = clamp_extent(sx, 128) * clamp_extent(sy, 128) * sz;
            grids = $urandom_range(1, 2);
            mask_pct = ($urandom_range(4) == 0) ? 50 : 97;
            // abandoned grid now and then, restarted by the next register write
            if (fill_run) begin
                held = 1;
                hold_req = 1;
            end
            else if ($urandom_range(5) == 0) total = $urandom_range(1, total);
            else total = total * grids;
            for (cnt = 0; cnt < total; cnt++) begin
                idle_on = !(n_items >= 1100 && n_items < 1250);
                r = $urandom_range(99);
                v = (r < 8) ? 24'h7FFFFF : (r < 16) ? 24'h800000 : 24'($urandom);
                send_voxel(v, $urandom_range(99) < mask_pct);
                // mid-grid pause until every result has drained
                if (!paused && n_items == 1080) begin
                    paused = 1;
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    wait (pending_voxels.size() == 0);
                end
                if (n_items >= 1300) break;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        idle_on = 0;

        wait (pending_voxels.size() == 0);
        repeat (30) @(posedge clk);
        $display("covered %0d fine voxels over %0d grid shapes, %0d coarse voxels",
                 n_items, n_grids, n_results);
        $display("%0d coarse voxels took the full 27-point weighting, %0d mismatches",
                 n_weighted, errors);
        if (errors == 0 && pending_voxels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
src/mfwr3d_pkg.sv
src/mfwr3d_ram.sv
src/masked_full_weighting_restrict_3d.sv
tb/tb_masked_full_weighting_restrict_3d.sv
